/* rtl/jsu_pkg.sv */
`timescale 1ns / 1ps
// Package for the JSON string unescape block: scan modes, result kinds,
// character codes, decode state and result bank types, hex digit lookup.
// No dependencies.
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_HEX    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
	localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
	localparam logic [7:0]  LEAD_TWO      = 8'hC0;
	localparam logic [7:0]  LEAD_THREE    = 8'hE0;
	localparam logic [7:0]  CONT_MARK     = 8'h80;
	localparam logic [5:0]  CONT_MASK     = 6'h3F;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hex_value;
		logic [1:0]  hex_count;
	} scan_state_t;

	typedef struct packed {
		logic [1:0]       count;
		kind_t            kind;
		logic [2:0][7:0]  bytes;
	} result_t;

	// bit 4 set marks a byte that is not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] d;
		d = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) d = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) d = {1'b0, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) d = {1'b0, 4'(b - 8'h37)};
		return d;
	endfunction

endpackage

/* rtl/jsu_decode.sv */
`timescale 1ns / 1ps
// Decode step for one input item: next scan state and the result bank.
// Depends on jsu_pkg.
module jsu_decode (
	input  jsu_pkg::scan_state_t cur,
	input  logic [7:0]           data_byte,
	input  logic                 at_end,
	output jsu_pkg::scan_state_t nxt,
	output jsu_pkg::result_t     res
);

	logic [4:0]  digit;
	logic [15:0] cp;

	assign digit = jsu_pkg::hex_digit(data_byte);
	assign cp    = {cur.hex_value[11:0], digit[3:0]};

	always_comb begin
		nxt       = cur;
		res.count = 2'd0;
		res.kind  = jsu_pkg::KIND_DATA;
		res.bytes = '0;
		if (at_end) begin
			nxt.mode      = jsu_pkg::MODE_NORMAL;
			nxt.hex_value = '0;
			nxt.hex_count = '0;
			res.count     = 2'd1;
			res.kind      = jsu_pkg::KIND_ERROR;
		end else begin
			case (cur.mode)
				jsu_pkg::MODE_ESCAPE: begin
					nxt.mode     = jsu_pkg::MODE_NORMAL;
					res.count    = 2'd1;
					res.bytes[0] = data_byte;
					case (data_byte)
						jsu_pkg::CH_N: res.bytes[0] = jsu_pkg::CH_LF;
						jsu_pkg::CH_T: res.bytes[0] = jsu_pkg::CH_TAB;
						jsu_pkg::CH_R: res.bytes[0] = jsu_pkg::CH_CR;
						jsu_pkg::CH_B: res.bytes[0] = jsu_pkg::CH_BS;
						jsu_pkg::CH_F: res.bytes[0] = jsu_pkg::CH_FF;
						jsu_pkg::CH_U: begin
							nxt.mode      = jsu_pkg::MODE_HEX;
							nxt.hex_value = '0;
							nxt.hex_count = '0;
							res.count     = 2'd0;
							res.bytes[0]  = '0;
						end
						default: res.bytes[0] = data_byte;
					endcase
				end
				jsu_pkg::MODE_HEX: begin
					if (digit[4]) begin
						nxt.mode      = jsu_pkg::MODE_NORMAL;
						nxt.hex_value = '0;
						nxt.hex_count = '0;
						res.count     = 2'd1;
						res.kind      = jsu_pkg::KIND_ERROR;
					end else if (cur.hex_count != 2'd3) begin
						nxt.hex_value = cp;
						nxt.hex_count = cur.hex_count + 2'd1;
					end else begin
						nxt.mode      = jsu_pkg::MODE_NORMAL;
						nxt.hex_value = '0;
						nxt.hex_count = '0;
						if (cp < jsu_pkg::CP_TWO_BYTE) begin
							res.count    = 2'd1;
							res.bytes[0] = cp[7:0];
						end else if (cp < jsu_pkg::CP_THREE_BYTE) begin
							res.count    = 2'd2;
							res.bytes[0] = jsu_pkg::LEAD_TWO | {3'b000, cp[10:6]};
							res.bytes[1] = jsu_pkg::CONT_MARK | {2'b00, cp[5:0] & jsu_pkg::CONT_MASK};
						end else begin
							res.count    = 2'd3;
							res.bytes[0] = jsu_pkg::LEAD_THREE | {4'h0, cp[15:12]};
							res.bytes[1] = jsu_pkg::CONT_MARK | {2'b00, cp[11:6] & jsu_pkg::CONT_MASK};
							res.bytes[2] = jsu_pkg::CONT_MARK | {2'b00, cp[5:0] & jsu_pkg::CONT_MASK};
						end
					end
				end
				default: begin
					nxt.mode = jsu_pkg::MODE_NORMAL;
					if (data_byte == jsu_pkg::CH_QUOTE) begin
						nxt.hex_value = '0;
						nxt.hex_count = '0;
						res.count     = 2'd1;
						res.kind      = jsu_pkg::KIND_DONE;
					end else if (data_byte == jsu_pkg::CH_BSLASH) begin
						nxt.mode = jsu_pkg::MODE_ESCAPE;
					end else begin
						res.count    = 2'd1;
						res.bytes[0] = data_byte;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/json_string_unescape_core.sv */
`timescale 1ns / 1ps
// JSON string body unescaper, top level: input stage, decode, result bank.
// Depends on jsu_pkg and jsu_decode.
//
// Takes one byte of a JSON string body per item (tuser set marks end of
// source) and emits decoded bytes, a completion marker on the closing quote
// or an error on a bad hex digit or early end. An item waits in the input
// register until the result bank can take its results, which are then
// registered in the bank and presented from there. One item is taken per
// cycle while each gives at most one result and the output is not stalled;
// a u-escape that encodes to two or three UTF-8 bytes holds the input
// register while the result bank drains one result per cycle as the output accepts them.
module json_string_unescape_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] at_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	jsu_pkg::scan_state_t st_q;
	jsu_pkg::scan_state_t st_nxt;
	jsu_pkg::result_t     res;
	logic [2:0][7:0]      bytes_q;
	jsu_pkg::kind_t       kind_q;
	logic [1:0]           n_q;
	logic                 pop;
	logic                 advance;

	jsu_decode u_decode (
		.cur       (st_q),
		.data_byte (byte_s1),
		.at_end    (end_s1),
		.nxt       (st_nxt),
		.res       (res)
	);

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign advance       = valid_s1 && (n_q == 2'd0 || (n_q == 2'd1 && m_axis_tready));
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: jsu_pkg::MODE_NORMAL, hex_value: '0, hex_count: '0};
			n_q  <= 2'd0;
		end else if (advance) begin
			st_q <= st_nxt;
			n_q  <= res.count;
		end else if (pop) begin
			n_q <= n_q - 2'd1;
		end
	end

	// hold, or load a fresh bank, or advance to the next byte
	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_q <= res.bytes;
			kind_q  <= res.kind;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[2], bytes_q[1]};
		end
	end

	assign m_axis_tvalid = n_q != 2'd0;
	assign m_axis_tdata  = bytes_q[0];
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = n_q == 2'd1;

	a_marker_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind_q != jsu_pkg::KIND_DATA |-> n_q == 2'd1 && m_axis_tdata == 8'h00)
		else $error("marker result not alone or carries data");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.count != 2'd0 |=> m_axis_tvalid)
		else $error("loaded results not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> n_q == 2'd0 || (n_q == 2'd1 && pop))
		else $error("result bank overwritten before drained");

	a_hex_only_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode != jsu_pkg::MODE_HEX |-> st_q.hex_count == 2'd0)
		else $error("hex digit count outside hex escape");

endmodule
